FILE: hw/rtl/fse_pkg.sv
// fse_pkg: shared constants, types and the fibonacci rom for the search engine
// no dependencies; used by fse_store and fibonacci_search_engine

package fse_pkg;

    // store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 10;

    // signed span for lo, hi and probe position (covers -1 .. 2*DEPTH)
    localparam int SPAN_W = ADDR_W + 3;

    // fibonacci rom
    localparam int FIB_N  = 40;
    localparam int FIDX_W = $clog2(FIB_N);

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef logic [31:0] t_fib_rom [FIB_N];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_HOLD
    } t_state;

    // F(0)=0, F(1)=F(2)=1, F(i)=F(i-1)+F(i-2)
    function automatic t_fib_rom build_fib_rom();
        t_fib_rom rom;
        rom[0] = 32'd0;
        rom[1] = 32'd1;
        rom[2] = 32'd1;
        for (int i = 3; i < FIB_N; i++) begin
            rom[i] = rom[i-1] + rom[i-2];
        end
        return rom;
    endfunction

    localparam t_fib_rom FIB_ROM = build_fib_rom();

    // starting index: k-1 for the smallest k with F(k) >= DEPTH+1
    function automatic int first_fib_index();
        t_fib_rom rom;
        int       k;
        logic     busy;
        rom  = build_fib_rom();
        k    = 1;
        busy = 1'b1;
        for (int i = 1; i < FIB_N - 1; i++) begin
            if (busy && rom[i] < 32'(DEPTH + 1)) begin
                k = i + 1;
            end else begin
                busy = 1'b0;
            end
        end
        return k - 1;
    endfunction

    localparam int F_START = first_fib_index();

endpackage

FILE: hw/rtl/fse_store.sv
// fse_store: value store, one write port and one read port, registered read
// depends on fse_pkg for depth and widths

module fse_store (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [fse_pkg::ADDR_W-1:0]        i_waddr,
    input  logic signed [fse_pkg::DATA_W-1:0] i_wdata,
    input  logic [fse_pkg::ADDR_W-1:0]        i_raddr,
    output logic signed [fse_pkg::DATA_W-1:0] o_rdata
);

    logic signed [fse_pkg::DATA_W-1:0] r_mem [fse_pkg::DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data registered and valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hw/rtl/fibonacci_search_engine.sv
// Fibonacci search engine over a store of 1024 signed 32-bit entries that the
// user must keep in ascending order (not enforced). A write item (command 0)
// stores its value at entry_index without stalling; it gives no result. A
// search item (command 1) runs Fibonacci search for the key and gives one
// result: found and, on a hit, the position. A probe inside the store reads
// the store in ST_PROBE and compares the registered data in ST_CMP; a probe
// past the end moves left in ST_PROBE without a read. With 1024 entries a
// search makes at most 16 probes; every probe inside the store goes through
// the single store read port. The input is stalled for the whole search; a
// finished result sits in the output register until it is taken.
// depends on fse_pkg and fse_store

module fibonacci_search_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_command,
    input  logic [fse_pkg::IDX_W-1:0]  i_entry_index,
    input  logic signed [31:0]         i_value,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_found,
    output logic [fse_pkg::POS_W-1:0]  o_position
);

    localparam int ADDR_W = fse_pkg::ADDR_W;
    localparam int SPAN_W = fse_pkg::SPAN_W;
    localparam int FIDX_W = fse_pkg::FIDX_W;
    localparam int POS_W  = fse_pkg::POS_W;

    localparam logic signed [SPAN_W-1:0] DEPTH_S = SPAN_W'(fse_pkg::DEPTH);
    localparam logic signed [SPAN_W-1:0] ONE_S   = SPAN_W'(1);
    localparam logic signed [FIDX_W:0]   F_INIT  = (FIDX_W + 1)'(fse_pkg::F_START);
    localparam logic signed [FIDX_W:0]   F_ONE   = (FIDX_W + 1)'(1);
    localparam logic signed [FIDX_W:0]   F_TWO   = (FIDX_W + 1)'(2);

    fse_pkg::t_state r_state, n_state;

    logic signed [SPAN_W-1:0] r_lo, n_lo;
    logic signed [SPAN_W-1:0] r_hi, n_hi;
    logic signed [SPAN_W-1:0] r_mid, n_mid;
    logic signed [FIDX_W:0]   r_f, n_f;
    logic signed [31:0]       r_key, n_key;
    logic                     r_res_found, n_res_found;
    logic [POS_W-1:0]         r_res_pos, n_res_pos;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_found, n_out_found;
    logic [POS_W-1:0]         r_out_pos, n_out_pos;

    logic                     in_take;
    logic                     out_free;
    logic [31:0]              idx_ext;
    logic                     st_we;
    logic [ADDR_W-1:0]        st_waddr;
    logic [ADDR_W-1:0]        st_raddr;
    logic signed [31:0]       st_rdata;
    logic [31:0]              fib_word;
    logic signed [SPAN_W-1:0] fib_val;
    logic signed [SPAN_W-1:0] probe;
    logic [31:0]              mid_ext;

    // handshakes
    assign o_stall  = (r_state != fse_pkg::ST_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // store write path
    assign idx_ext  = 32'(i_entry_index);
    assign st_we    = in_take && (i_command == fse_pkg::CMD_WRITE) &&
                      (idx_ext < 32'(fse_pkg::DEPTH));
    assign st_waddr = idx_ext[ADDR_W-1:0];

    // probe position lo + F(f) - 1
    assign fib_word = fse_pkg::FIB_ROM[r_f[FIDX_W-1:0]];
    assign fib_val  = $signed(fib_word[SPAN_W-1:0]);
    assign probe    = r_lo + fib_val - ONE_S;
    assign st_raddr = probe[ADDR_W-1:0];
    assign mid_ext  = 32'(r_mid);

    fse_store u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (i_value),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_f         = r_f;
        n_key       = r_key;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fse_pkg::ST_IDLE: begin
                if (in_take && (i_command == fse_pkg::CMD_SEARCH)) begin
                    n_lo    = '0;
                    n_hi    = DEPTH_S - ONE_S;
                    n_f     = F_INIT;
                    n_key   = i_value;
                    n_state = fse_pkg::ST_PROBE;
                end
            end
            fse_pkg::ST_PROBE: begin
                if (!(r_lo <= r_hi) || (r_f < F_ONE)) begin
                    // bounds crossed or fibonacci index used up: miss
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    n_state     = fse_pkg::ST_HOLD;
                end else if (probe >= DEPTH_S) begin
                    // past the end, move left without a read
                    n_hi = probe - ONE_S;
                    n_f  = r_f - F_ONE;
                end else begin
                    n_mid   = probe;
                    n_state = fse_pkg::ST_CMP;
                end
            end
            fse_pkg::ST_CMP: begin
                if (st_rdata == r_key) begin
                    n_res_found = 1'b1;
                    n_res_pos   = mid_ext[POS_W-1:0];
                    n_state     = fse_pkg::ST_HOLD;
                end else if (st_rdata > r_key) begin
                    n_hi    = r_mid - ONE_S;
                    n_f     = r_f - F_ONE;
                    n_state = fse_pkg::ST_PROBE;
                end else begin
                    n_lo    = r_mid + ONE_S;
                    n_f     = r_f - F_TWO;
                    n_state = fse_pkg::ST_PROBE;
                end
            end
            fse_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_pos   = r_res_pos;
                    n_state     = fse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fse_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fse_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_f         <= n_f;
        r_key       <= n_key;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule
